// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);
`else
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== hdl/tpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Tilt plate motor package
// Word types, CORDIC and divider cell types and fixed constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpm_pkg;

  localparam int REM_W = 57;
  localparam int DEN_W = 32;
  localparam int QUO_W = 25;

  localparam logic [1:0] CFG_MAX_TILT = 2'd0;
  localparam logic [1:0] CFG_INVERT_X = 2'd1;
  localparam logic [1:0] CFG_INVERT_Y = 2'd2;

  localparam logic [14:0] TILT_LIMIT_CAP = 15'd21760;
  localparam logic [14:0] MAX_TILT_RESET = 15'd7680;
  localparam logic signed [31:0] CORDIC_KINV = 32'sd652032874;

  localparam logic signed [31:0] ATAN_TAB [0:23] = '{
    32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
    32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
    32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
    32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA, 32'sh0000517D,
    32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
    32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051
  };

  typedef struct packed {
    logic        [15:0] azimuth;
    logic signed [15:0] tilt;
    logic signed [23:0] azimuth_rate;
    logic signed [23:0] tilt_rate;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] x_angle;
    logic signed [15:0] y_angle;
    logic signed [23:0] x_rate;
    logic signed [23:0] y_rate;
    logic               status;
  } out_word_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [31:0] z;
  } cordic_t;

  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
  } div_t;

endpackage

// ===== hdl/tpm_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// CORDIC cell
// One registered micro-rotation, in rotation or vectoring mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpm_cordic_cell #(
  parameter int STEP      = 0,
  parameter bit VECTORING = 1'b0
) (
  input  logic            clk,
  input  tpm_pkg::cordic_t cell_in,
  output tpm_pkg::cordic_t cell_out
);

  tpm_pkg::cordic_t   cell_r;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [31:0] ang;
  logic               plus;

  assign xs  = cell_in.x >>> STEP;
  assign ys  = cell_in.y >>> STEP;
  assign ang = tpm_pkg::ATAN_TAB[STEP];

  // Vectoring drives y toward zero; rotation drives z toward zero.
  assign plus = VECTORING ? (cell_in.y <= 34'sd0) : (cell_in.z >= 32'sd0);

  always_ff @(posedge clk) begin
    if (plus) begin
      cell_r.x <= cell_in.x - ys;
      cell_r.y <= cell_in.y + xs;
      cell_r.z <= cell_in.z - ang;
    end else begin
      cell_r.x <= cell_in.x + ys;
      cell_r.y <= cell_in.y - xs;
      cell_r.z <= cell_in.z + ang;
    end
  end

  assign cell_out = cell_r;

endmodule

// ===== hdl/tpm_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One registered restoring-division step producing one quotient bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpm_div_cell #(
  parameter int BIT = 0
) (
  input  logic          clk,
  input  tpm_pkg::div_t cell_in,
  output tpm_pkg::div_t cell_out
);

  tpm_pkg::div_t             cell_r;
  logic [tpm_pkg::REM_W-1:0] trial;
  logic                      fit;

  assign trial = tpm_pkg::REM_W'(cell_in.den) << BIT;
  assign fit   = cell_in.rem >= trial;

  always_ff @(posedge clk) begin
    cell_r.neg <= cell_in.neg;
    cell_r.ovf <= cell_in.ovf;
    cell_r.den <= cell_in.den;
    cell_r.rem <= fit ? cell_in.rem - trial : cell_in.rem;
    cell_r.quo <= fit ? cell_in.quo | (tpm_pkg::QUO_W'(1) << BIT) : cell_in.quo;
  end

  assign cell_out = cell_r;

endmodule

// ===== hdl/tilt_plate_motor_angle_rate.sv =====
// ----------------------------------------------------------------------------
// Tilt plate motor angle and rate
// Converts a plate tilt setpoint and its rates into two motor angles and rates.
// ----------------------------------------------------------------------------
// Usage: drive in_word and raise start; a word is taken at every clock edge
// where start is high and busy is low. busy stays low, so a new word may be
// offered in every cycle and the block sustains one word per clock.
// Each word gives exactly one result word on out_word, marked by out_valid
// for one cycle. The word passes a chain of cells: four registers to turn
// the tilt into a binary angle, a rotation CORDIC of CORDIC_ITERATIONS cells
// for the sines and cosines, five product stages, one divider setup stage,
// a 25-cell restoring divider for the rates and the output register; the
// vectoring CORDIC for the angles runs beside the divider.
// The receiver cannot hold results off; out_valid is a strobe.
// Configuration is written through cfg_we, cfg_index and cfg_data while no
// word is in flight. Register 0 is the tilt limit, 1 and 2 the axis inverts.
// Synchronous reset clears the pipeline valid bits and loads the register
// reset values; words in flight are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tilt_plate_motor_angle_rate #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tpm_pkg::in_word_t  in_word,
  output logic               out_valid,
  output tpm_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data
);

  localparam int N       = CORDIC_ITERATIONS;
  localparam int S_M1    = N + 4;
  localparam int S_M3    = N + 6;
  localparam int S_M5    = N + 8;
  localparam int S_LAST  = N + 34;
  localparam int ANG_S   = 2 * N + 6;
  localparam int ANG_LEN = 28 - N;
  localparam int LAT     = N + 36;

  typedef struct packed {
    logic               bad;
    logic               inv_x;
    logic               inv_y;
    logic signed [23:0] w;
    logic signed [23:0] r;
  } side_t;

  typedef struct packed {
    logic [1:0]         quad;
    logic signed [31:0] z;
  } prep_t;

  typedef struct packed {
    logic signed [31:0] s;
    logic signed [31:0] c;
  } sc_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } ang_t;

  // Products of two Q2.30 values, rounded back to Q2.30.
  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    begin
      p = 64'(a) * 64'(b) + 64'sd536870912;
      mulq = p[61:30];
    end
  endfunction

  // Nearest quadrant and residual angle for the rotation CORDIC.
  function automatic prep_t rot_prep(input logic [31:0] ang);
    logic [31:0] sum;
    prep_t       res;
    begin
      sum      = ang + 32'h2000_0000;
      res.quad = sum[31:30];
      res.z    = signed'({2'b00, sum[29:0]}) - 32'sh2000_0000;
      rot_prep = res;
    end
  endfunction

  function automatic sc_t quad_map(input logic [1:0] quad, input tpm_pkg::cordic_t v);
    logic signed [31:0] x;
    logic signed [31:0] y;
    sc_t                res;
    begin
      x = v.x[31:0];
      y = v.y[31:0];
      unique case (quad)
        2'd0: begin res.c = x;  res.s = y;  end
        2'd1: begin res.c = -y; res.s = x;  end
        2'd2: begin res.c = -x; res.s = -y; end
        2'd3: begin res.c = y;  res.s = -x; end
      endcase
      quad_map = res;
    end
  endfunction

  // Magnitude, rounding offset and overflow check ahead of the divider.
  function automatic tpm_pkg::div_t div_prep(input logic signed [56:0] num,
                                             input logic signed [32:0] den,
                                             input logic inv);
    logic [56:0]   m;
    logic [31:0]   d;
    logic [57:0]   dividend;
    tpm_pkg::div_t res;
    begin
      m        = num[56] ? 57'(-num) : 57'(num);
      d        = (den <= 33'sd0) ? 32'd1 : den[31:0];
      dividend = {1'b0, m} + {27'b0, d[31:1]};
      res.neg  = num[56] ^ inv;
      res.ovf  = dividend >= {1'b0, d, 25'b0};
      res.rem  = dividend[56:0];
      res.den  = d;
      res.quo  = '0;
      div_prep = res;
    end
  endfunction

  // Apply the sign and saturate a quotient to the rate field.
  function automatic logic signed [23:0] rate_sat(input tpm_pkg::div_t d);
    begin
      if (d.neg) begin
        rate_sat = (d.ovf || d.quo > 25'h080_0000) ? 24'sh800000 : -signed'(d.quo[23:0]);
      end else begin
        rate_sat = (d.ovf || d.quo > 25'h07F_FFFF) ? 24'sh7FFFFF : signed'(d.quo[23:0]);
      end
    end
  endfunction

  // Binary angle times degrees per turn, rounded to Q8.8, signed, saturated.
  function automatic logic signed [15:0] ang_fin(input logic signed [49:0] p,
                                                 input logic inv);
    logic signed [49:0] sum;
    logic signed [17:0] t;
    begin
      sum = p + 50'sd2147483648;
      t   = sum[49:32];
      if (inv) begin
        t = -t;
      end
      if (t > 18'sd32767) begin
        ang_fin = 16'sh7FFF;
      end else if (t < -18'sd32768) begin
        ang_fin = 16'sh8000;
      end else begin
        ang_fin = t[15:0];
      end
    end
  endfunction

  // Configuration registers.
  logic [14:0] max_tilt_r;
  logic        inv_x_r;
  logic        inv_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tilt_r <= tpm_pkg::MAX_TILT_RESET;
      inv_x_r    <= 1'b0;
      inv_y_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpm_pkg::CFG_MAX_TILT: max_tilt_r <= cfg_data;
        tpm_pkg::CFG_INVERT_X: inv_x_r    <= cfg_data[0];
        tpm_pkg::CFG_INVERT_Y: inv_y_r    <= cfg_data[0];
        default:               ;
      endcase
    end
  end

  // The pipeline never stalls, so a word is taken whenever start is high.
  assign busy = 1'b0;

  logic        accept;
  logic [15:0] in_mag;
  logic [14:0] lim;
  logic        in_bad;

  assign accept = start && !busy;
  assign in_mag = in_word.tilt[15] ? 16'(-in_word.tilt) : 16'(in_word.tilt);
  assign lim    = (max_tilt_r > tpm_pkg::TILT_LIMIT_CAP) ? tpm_pkg::TILT_LIMIT_CAP
                                                         : max_tilt_r;
  assign in_bad = in_mag > {1'b0, lim};

  // Valid bits and sideband travel down shift lines beside the cells.
  logic [S_LAST:0] valid_r;
  side_t           side_r [0:S_LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[S_LAST-1:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= '{bad: in_bad, inv_x: inv_x_r, inv_y: inv_y_r,
                   w: in_word.azimuth_rate, r: in_word.tilt_rate};
    for (int k = 1; k <= S_LAST; k++) begin
      side_r[k] <= side_r[k-1];
    end
  end

  // Tilt to binary angle: mag * 2^24 / 360, rounded, split as
  // 46603 * mag + (17 * mag + 22) / 45, the small quotient by reciprocal.
  logic [15:0] az0_r, az1_r, az2_r, az3_r;
  logic [15:0] mag0_r;
  logic        neg0_r, neg1_r, neg2_r;
  logic [31:0] prod1_r, prod2_r;
  logic [20:0] v1_r;
  logic [15:0] q2_r;
  logic [31:0] ti3_r;
  logic [39:0] rec;
  logic [31:0] ti_sum;

  assign rec    = {19'b0, v1_r} * 40'd372828;
  assign ti_sum = prod2_r + {16'b0, q2_r};

  always_ff @(posedge clk) begin
    az0_r   <= in_word.azimuth;
    mag0_r  <= in_mag;
    neg0_r  <= in_word.tilt[15];
    az1_r   <= az0_r;
    neg1_r  <= neg0_r;
    prod1_r <= {16'b0, mag0_r} * 32'd46603;
    v1_r    <= {5'b0, mag0_r} * 21'd17 + 21'd22;
    az2_r   <= az1_r;
    neg2_r  <= neg1_r;
    prod2_r <= prod1_r;
    q2_r    <= rec[39:24];
    az3_r   <= az2_r;
    ti3_r   <= neg2_r ? -ti_sum : ti_sum;
  end

  // Rotation CORDIC chains for azimuth and tilt.
  prep_t            prep_a, prep_t_w;
  tpm_pkg::cordic_t rot_a [0:N];
  tpm_pkg::cordic_t rot_t [0:N];
  logic [1:0]       quad_a_r [0:N-1];
  logic [1:0]       quad_t_r [0:N-1];

  assign prep_a   = rot_prep({az3_r, 16'b0});
  assign prep_t_w = rot_prep(ti3_r);

  always_comb begin
    rot_a[0] = '{x: 34'(tpm_pkg::CORDIC_KINV), y: 34'sd0, z: prep_a.z};
    rot_t[0] = '{x: 34'(tpm_pkg::CORDIC_KINV), y: 34'sd0, z: prep_t_w.z};
  end

  always_ff @(posedge clk) begin
    quad_a_r[0] <= prep_a.quad;
    quad_t_r[0] <= prep_t_w.quad;
    for (int k = 1; k < N; k++) begin
      quad_a_r[k] <= quad_a_r[k-1];
      quad_t_r[k] <= quad_t_r[k-1];
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_rot
    tpm_cordic_cell #(.STEP(j), .VECTORING(1'b0)) u_rot_a (
      .clk(clk), .cell_in(rot_a[j]), .cell_out(rot_a[j+1]));
    tpm_cordic_cell #(.STEP(j), .VECTORING(1'b0)) u_rot_t (
      .clk(clk), .cell_in(rot_t[j]), .cell_out(rot_t[j+1]));
  end

  // Sines and cosines put back in their quadrant.
  sc_t sc_a_r, sc_t_r;

  always_ff @(posedge clk) begin
    sc_a_r <= quad_map(quad_a_r[N-1], rot_a[N]);
    sc_t_r <= quad_map(quad_t_r[N-1], rot_t[N]);
  end

  // First products: the atan2 arguments, sin t cos t, cos^2 t and the tilt
  // rate terms of both numerators.
  logic signed [31:0] m2_sxn_r, m2_syn_r, m2_sct_r, m2_cc_r, m2_ct_r, m2_sa_r, m2_ca_r;
  logic signed [55:0] m2_car_r, m2_sar_r;

  always_ff @(posedge clk) begin
    m2_sxn_r <= mulq(sc_t_r.s, sc_a_r.c);
    m2_syn_r <= -mulq(sc_t_r.s, sc_a_r.s);
    m2_sct_r <= mulq(sc_t_r.s, sc_t_r.c);
    m2_cc_r  <= mulq(sc_t_r.c, sc_t_r.c);
    m2_ct_r  <= sc_t_r.c;
    m2_sa_r  <= sc_a_r.s;
    m2_ca_r  <= sc_a_r.c;
    m2_car_r <= 56'(sc_a_r.c) * 56'(side_r[S_M1].r);
    m2_sar_r <= 56'(sc_a_r.s) * 56'(side_r[S_M1].r);
  end

  // Second products: the squared atan2 arguments and the azimuth rate
  // coefficients.
  logic signed [31:0] m3_sxn2_r, m3_syn2_r, m3_ps_r, m3_pc_r, m3_cc_r;
  logic signed [55:0] m3_car_r, m3_sar_r;

  always_ff @(posedge clk) begin
    m3_sxn2_r <= mulq(m2_sxn_r, m2_sxn_r);
    m3_syn2_r <= mulq(m2_syn_r, m2_syn_r);
    m3_ps_r   <= mulq(m2_sct_r, m2_sa_r);
    m3_pc_r   <= mulq(m2_sct_r, m2_ca_r);
    m3_cc_r   <= m2_cc_r;
    m3_car_r  <= m2_car_r;
    m3_sar_r  <= m2_sar_r;
  end

  // Denominators and the azimuth rate terms.
  logic signed [32:0] m4_dx_r, m4_dy_r;
  logic signed [55:0] m4_psw_r, m4_pcw_r, m4_car_r, m4_sar_r;

  always_ff @(posedge clk) begin
    m4_dx_r  <= 33'(m3_cc_r) + 33'(m3_sxn2_r);
    m4_dy_r  <= 33'(m3_cc_r) + 33'(m3_syn2_r);
    m4_psw_r <= 56'(m3_ps_r) * 56'(side_r[S_M3].w);
    m4_pcw_r <= 56'(m3_pc_r) * 56'(side_r[S_M3].w);
    m4_car_r <= m3_car_r;
    m4_sar_r <= m3_sar_r;
  end

  // Numerators.
  logic signed [56:0] m5_numx_r, m5_numy_r;
  logic signed [32:0] m5_dx_r, m5_dy_r;

  always_ff @(posedge clk) begin
    m5_numx_r <= 57'(m4_car_r) - 57'(m4_psw_r);
    m5_numy_r <= -57'(m4_sar_r) - 57'(m4_pcw_r);
    m5_dx_r   <= m4_dx_r;
    m5_dy_r   <= m4_dy_r;
  end

  // Divider chains, one quotient bit per cell from the top bit down.
  tpm_pkg::div_t div_x [0:tpm_pkg::QUO_W];
  tpm_pkg::div_t div_y [0:tpm_pkg::QUO_W];

  always_ff @(posedge clk) begin
    div_x[0] <= div_prep(m5_numx_r, m5_dx_r, side_r[S_M5].inv_x);
    div_y[0] <= div_prep(m5_numy_r, m5_dy_r, side_r[S_M5].inv_y);
  end

  for (genvar k = 0; k < tpm_pkg::QUO_W; k++) begin : g_div
    tpm_div_cell #(.BIT(tpm_pkg::QUO_W - 1 - k)) u_div_x (
      .clk(clk), .cell_in(div_x[k]), .cell_out(div_x[k+1]));
    tpm_div_cell #(.BIT(tpm_pkg::QUO_W - 1 - k)) u_div_y (
      .clk(clk), .cell_in(div_y[k]), .cell_out(div_y[k+1]));
  end

  // Vectoring CORDIC chains for the motor angles, beside the divider.
  tpm_pkg::cordic_t vec_x [0:N];
  tpm_pkg::cordic_t vec_y [0:N];

  always_comb begin
    vec_x[0] = '{x: 34'(m2_ct_r), y: 34'(m2_sxn_r), z: 32'sd0};
    vec_y[0] = '{x: 34'(m2_ct_r), y: 34'(m2_syn_r), z: 32'sd0};
  end

  for (genvar j = 0; j < N; j++) begin : g_vec
    tpm_cordic_cell #(.STEP(j), .VECTORING(1'b1)) u_vec_x (
      .clk(clk), .cell_in(vec_x[j]), .cell_out(vec_x[j+1]));
    tpm_cordic_cell #(.STEP(j), .VECTORING(1'b1)) u_vec_y (
      .clk(clk), .cell_in(vec_y[j]), .cell_out(vec_y[j+1]));
  end

  // Angles to degrees, then held until the rates catch up.
  logic signed [49:0] ang_px_r, ang_py_r;
  ang_t               ang_d [0:ANG_LEN-1];

  always_ff @(posedge clk) begin
    ang_px_r <= 50'(vec_x[N].z) * 50'sd92160;
    ang_py_r <= 50'(vec_y[N].z) * 50'sd92160;
    ang_d[0] <= '{x: ang_fin(ang_px_r, side_r[ANG_S].inv_x),
                  y: ang_fin(ang_py_r, side_r[ANG_S].inv_y)};
    for (int k = 1; k < ANG_LEN; k++) begin
      ang_d[k] <= ang_d[k-1];
    end
  end

  // Output register; an out-of-range tilt gives status 1 and zero fields.
  logic               out_valid_r;
  tpm_pkg::out_word_t out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= valid_r[S_LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (side_r[S_LAST].bad) begin
      out_word_r <= '{x_angle: 16'sd0, y_angle: 16'sd0, x_rate: 24'sd0,
                      y_rate: 24'sd0, status: 1'b1};
    end else begin
      out_word_r <= '{x_angle: ang_d[ANG_LEN-1].x, y_angle: ang_d[ANG_LEN-1].y,
                      x_rate: rate_sat(div_x[tpm_pkg::QUO_W]),
                      y_rate: rate_sat(div_y[tpm_pkg::QUO_W]), status: 1'b0};
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Short terms that the checks below are built from.
  logic out_zero;
  logic out_ok;
  logic ang_at_min;

  assign out_zero   = (out_word.x_angle == 16'sd0) && (out_word.y_angle == 16'sd0) &&
                      (out_word.x_rate == 24'sd0) && (out_word.y_rate == 24'sd0);
  assign out_ok     = out_valid && !out_word.status;
  assign ang_at_min = (out_word.x_angle == 16'sh8000) || (out_word.y_angle == 16'sh8000);

  // A range error must blank every other field.
  `ASSERT_IMPLY(a_range_blank, out_valid && out_word.status, out_zero, "range status with data")
  // Every result stems from a word taken exactly one latency earlier.
  `ASSERT_IMPLY(a_latency, out_valid, $past(start && !busy, LAT), "result without input word")
  // The most negative tilt code is never in range.
  `ASSERT_IMPLY(a_min_tilt, out_ok, $past(in_word.tilt != 16'sh8000, LAT), "min tilt in range")
  // Motor angles stay within a quarter turn, far from the field limit.
  `ASSERT_NEVER(a_angle_span, out_ok && ang_at_min, "motor angle at field limit")

endmodule

// ===== test/tpm_checker.sv =====
// ----------------------------------------------------------------------------
// Tilt plate motor result checker
// Watches accepted words, computes the expected motor angles and rates and
// compares every result word field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpm_checker #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  tpm_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  tpm_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data,
  output int                 fail_count,
  output int                 pending_count,
  output int                 result_count,
  output int                 range_count
);

  logic [14:0]        lim_reg;
  logic               inv_x_reg;
  logic               inv_y_reg;
  tpm_pkg::out_word_t motor_queue[$];

  function automatic longint unsigned cordic_steps();
    return (CORDIC_ITERATIONS > 24) ? 24 : CORDIC_ITERATIONS;
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  task automatic rotate_sin_cos(input logic [31:0] ang, output longint s,
                                output longint c);
    logic [31:0] shifted;
    longint z, x, y, nx, ny;
    shifted = ang + 32'h2000_0000;
    z = longint'({32'd0, 2'b00, shifted[29:0]}) - 64'sh2000_0000;
    x = tpm_pkg::CORDIC_KINV;
    y = 0;
    for (int i = 0; i < cordic_steps(); i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= tpm_pkg::ATAN_TAB[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += tpm_pkg::ATAN_TAB[i];
      end
      x = nx; y = ny;
    end
    case (shifted[31:30])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  function automatic longint vector_angle_q88(longint y, longint x);
    longint z, nx, ny;
    z = 0;
    for (int i = 0; i < cordic_steps(); i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += tpm_pkg::ATAN_TAB[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= tpm_pkg::ATAN_TAB[i];
      end
      x = nx; y = ny;
    end
    return (z * 92160 + (64'sd1 <<< 31)) >>> 32;
  endfunction

  function automatic longint round_divide(longint num, longint den);
    longint unsigned m, q;
    if (den <= 0) den = 1;
    m = (num < 0) ? -num : num;
    q = (m + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic predict_motor(input tpm_pkg::in_word_t w, output tpm_pkg::out_word_t res);
    longint tilt, mag, lim, az_rate, tl_rate;
    longint sa, ca, st, ct, sxn, syn, sct, xa, ya, xr, yr, dx, dy;
    logic [31:0] ti;
    tilt = w.tilt;
    az_rate = w.azimuth_rate;
    tl_rate = w.tilt_rate;
    mag = (tilt < 0) ? -tilt : tilt;
    lim = (lim_reg > tpm_pkg::TILT_LIMIT_CAP) ? tpm_pkg::TILT_LIMIT_CAP : lim_reg;
    res = '0;
    if (mag > lim) begin
      res.status = 1'b1;
      return;
    end
    ti = 32'((mag * 16777216 + 180) / 360);
    if (tilt < 0) ti = -ti;
    rotate_sin_cos({w.azimuth, 16'd0}, sa, ca);
    rotate_sin_cos(ti, st, ct);
    sxn = mul_q30(st, ca);
    syn = -mul_q30(st, sa);
    xa = vector_angle_q88(sxn, ct);
    ya = vector_angle_q88(syn, ct);
    sct = mul_q30(st, ct);
    dx = mul_q30(ct, ct) + mul_q30(sxn, sxn);
    dy = mul_q30(ct, ct) + mul_q30(syn, syn);
    xr = round_divide(ca * tl_rate - mul_q30(sct, sa) * az_rate, dx);
    yr = round_divide(-sa * tl_rate - mul_q30(sct, ca) * az_rate, dy);
    if (inv_x_reg) begin xa = -xa; xr = -xr; end
    if (inv_y_reg) begin ya = -ya; yr = -yr; end
    res.x_angle = 16'(clamp(xa, -32768, 32767));
    res.y_angle = 16'(clamp(ya, -32768, 32767));
    res.x_rate = 24'(clamp(xr, -8388608, 8388607));
    res.y_rate = 24'(clamp(yr, -8388608, 8388607));
  endtask

  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  assign pending_count = motor_queue.size();

  always @(posedge clk) begin
    tpm_pkg::out_word_t res, want;
    if (!rst_n) begin
      lim_reg <= tpm_pkg::MAX_TILT_RESET;
      inv_x_reg <= 1'b0;
      inv_y_reg <= 1'b0;
      motor_queue.delete();
    end else begin
      if (out_valid) begin
        if (motor_queue.size() == 0) begin
          report_mismatch("unexpected result word", 1, 0);
        end else begin
          want = motor_queue.pop_front();
          result_count++;
          if (out_word.status !== want.status)
            report_mismatch("status", out_word.status, want.status);
          if (out_word.x_angle !== want.x_angle)
            report_mismatch("x_angle", out_word.x_angle, want.x_angle);
          if (out_word.y_angle !== want.y_angle)
            report_mismatch("y_angle", out_word.y_angle, want.y_angle);
          if (out_word.x_rate !== want.x_rate)
            report_mismatch("x_rate", out_word.x_rate, want.x_rate);
          if (out_word.y_rate !== want.y_rate)
            report_mismatch("y_rate", out_word.y_rate, want.y_rate);
        end
      end
      if (start && !busy) begin
        predict_motor(in_word, res);
        if (res.status) range_count++;
        motor_queue.push_back(res);
      end
      if (cfg_we) begin
        case (cfg_index)
          tpm_pkg::CFG_MAX_TILT: lim_reg <= cfg_data;
          tpm_pkg::CFG_INVERT_X: inv_x_reg <= cfg_data[0];
          tpm_pkg::CFG_INVERT_Y: inv_y_reg <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  initial begin
    fail_count = 0;
    result_count = 0;
    range_count = 0;
  end
endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Tilt plate motor testbench
// Drives directed and random tilt setpoints through several limit and invert
// settings while the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int ITERS = 16;
  // Pipeline depth from the block's own description, plus some margin.
  localparam int DRAIN_CYCLES = ITERS + 36 + 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 1250;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  tpm_pkg::in_word_t in_word;
  logic out_valid;
  tpm_pkg::out_word_t out_word;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [14:0] cfg_data;
  int fail_count, pending_count, result_count, range_count;
  int cycle_count;
  bit quiet_stretch;

  tilt_plate_motor_angle_rate #(.CORDIC_ITERATIONS(ITERS)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tpm_checker #(.CORDIC_ITERATIONS(ITERS)) checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .fail_count(fail_count),
    .pending_count(pending_count), .result_count(result_count),
    .range_count(range_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung pipeline or a lost word ends the run here.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Offer one word and hold it until the block takes it. Outside quiet
  // stretches the sender leaves a gap before a word about 16% of the time.
  task automatic send_word(input tpm_pkg::in_word_t w);
    while (!quiet_stretch && $urandom_range(99) < 16) begin
      start <= 1'b0;
      in_word <= tpm_pkg::in_word_t'({$urandom, $urandom, $urandom});
      @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_input();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Registers change only with the pipeline empty: wait for every expected
  // word, then the full pipeline depth in case something is still moving.
  task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
    idle_input();
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic tpm_pkg::in_word_t make_word(logic [15:0] az, logic [15:0] tl,
                                                  logic [23:0] ar, logic [23:0] tr);
    tpm_pkg::in_word_t w;
    w.azimuth = az;
    w.tilt = tl;
    w.azimuth_rate = ar;
    w.tilt_rate = tr;
    return w;
  endfunction

  // Mostly tilts inside the current limit so the trig path is exercised;
  // a fraction of arbitrary tilts covers the range status and sign bit.
  function automatic tpm_pkg::in_word_t random_word(int lim);
    tpm_pkg::in_word_t w;
    int mag;
    w = tpm_pkg::in_word_t'({$urandom, $urandom, $urandom});
    if ($urandom_range(9) < 8) begin
      mag = $urandom_range(lim);
      if ($urandom_range(9) == 0) mag = lim;
      w.tilt = ($urandom_range(1) != 0) ? 16'(-mag) : 16'(mag);
    end
    if ($urandom_range(3) == 0) begin
      w.azimuth_rate = 24'($signed($urandom_range(4000)) - 2000);
      w.tilt_rate = 24'($signed($urandom_range(4000)) - 2000);
    end
    return w;
  endfunction

  task automatic random_phase(input int count, input int lim);
    for (int i = 0; i < count; i++) begin
      quiet_stretch = (i >= count / 3) && (i < count / 2);
      send_word(random_word(lim));
    end
    quiet_stretch = 1'b0;
  endtask

  initial begin
    int eff_lim;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_index = tpm_pkg::CFG_MAX_TILT;
    cfg_data = '0;
    quiet_stretch = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at the reset limit of 30 degrees.
    send_word(make_word(16'd0, 16'sd0, 24'sd0, 24'sd0));
    send_word(make_word(16'hFFFF, 16'sd7680, 24'h7FFFFF, 24'h7FFFFF));
    send_word(make_word(16'h4000, -16'sd7680, 24'h800000, 24'h800000));
    send_word(make_word(16'h8000, 16'sd7681, 24'sd100, 24'sd100));
    send_word(make_word(16'hC000, 16'h8000, 24'sd0, 24'sd0));
    send_word(make_word(16'h2000, 16'h7FFF, 24'sd5, 24'sd5));
    send_word(make_word(16'h6000, 16'sd3840, 24'sd256, -24'sd256));
    send_word(make_word(16'hA000, -16'sd1, 24'h7FFFFF, 24'h800000));

    // Widest limit with both axes inverted: rate saturation after negation.
    write_reg(tpm_pkg::CFG_MAX_TILT, 15'h7FFF);
    write_reg(tpm_pkg::CFG_INVERT_X, 15'd1);
    write_reg(tpm_pkg::CFG_INVERT_Y, 15'd1);
    send_word(make_word(16'h0000, 16'sd21760, 24'h800000, 24'h800000));
    send_word(make_word(16'h4000, -16'sd21760, 24'h7FFFFF, 24'h800000));
    send_word(make_word(16'h2000, 16'sd21761, 24'sd0, 24'sd0));
    send_word(make_word(16'hE000, 16'sd20000, 24'h800000, 24'h7FFFFF));
    send_word(make_word(16'h1234, 16'h7FFF, 24'sd0, 24'sd0));
    send_word(make_word(16'h8000, -16'sd21760, 24'h7FFFFF, 24'h7FFFFF));

    // Zero limit: only zero tilt passes.
    write_reg(tpm_pkg::CFG_MAX_TILT, 15'd0);
    send_word(make_word(16'h5555, 16'sd0, 24'sd1000, 24'sd1000));
    send_word(make_word(16'hAAAA, 16'sd1, 24'sd0, 24'sd0));
    send_word(make_word(16'h3333, -16'sd1, 24'sd0, 24'sd0));

    // Random phases over several settings.
    random_phase(RANDOM_WORDS / 5, 0);
    write_reg(tpm_pkg::CFG_MAX_TILT, 15'd21760);
    write_reg(tpm_pkg::CFG_INVERT_X, 15'd0);
    random_phase(RANDOM_WORDS / 5, 21760);
    write_reg(tpm_pkg::CFG_MAX_TILT, 15'd7680);
    write_reg(tpm_pkg::CFG_INVERT_Y, 15'd0);
    random_phase(RANDOM_WORDS / 5, 7680);
    eff_lim = $urandom_range(21760);
    write_reg(tpm_pkg::CFG_MAX_TILT, 15'(eff_lim));
    write_reg(tpm_pkg::CFG_INVERT_X, 15'd1);
    random_phase(RANDOM_WORDS / 5, eff_lim);
    write_reg(tpm_pkg::CFG_MAX_TILT, 15'h7FFF);
    write_reg(tpm_pkg::CFG_INVERT_X, 15'd0);
    write_reg(tpm_pkg::CFG_INVERT_Y, 15'd1);
    random_phase(RANDOM_WORDS / 5, 21760);

    idle_input();
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d result words, %0d of them out of range,",
             result_count, range_count);
    $display("across five limit and invert settings.");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
